@@ rtl/core/hsl_pkg.sv @@
package hsl_pkg;

   // Field widths
   localparam int unsigned CH_W  = 8;
   // Numerators scaled by 255 over DEN, worst case 255*DEN + DEN/2
   localparam int unsigned NUM_W = 23;

   // Fixed-point denominator (510 * 42) and half of it for rounding
   localparam int unsigned DEN      = 21420;
   localparam int unsigned HALF_DEN = DEN / 2;

   // Hue geometry
   localparam int unsigned SECTOR_LEN = 42;
   localparam int unsigned HUE_PERIOD = 2 * SECTOR_LEN;

   // Reciprocal of DEN: floor(n / DEN) == (n * RECIP) >> RECIP_SHIFT
   // for every n below 2**NUM_W (shift = NUM_W + ceil(log2(DEN))).
   localparam int unsigned     RECIP_SHIFT = 38;
   localparam int unsigned     RECIP_W     = 24;
   localparam longint unsigned RECIP_L     =
      ((64'd1 << RECIP_SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   // Hue sector: which of (C+m, X+m, m) lands on red, green, blue
   typedef enum logic [2:0] {
      SEC_RED_YEL  = 3'd0,
      SEC_YEL_GRN  = 3'd1,
      SEC_GRN_CYN  = 3'd2,
      SEC_CYN_BLU  = 3'd3,
      SEC_BLU_MAG  = 3'd4,
      SEC_MAG_RED  = 3'd5
   } sector_type;

   // Numerators of the three candidate levels
   typedef struct packed {
      logic [NUM_W-1:0] nc;
      logic [NUM_W-1:0] nx;
      logic [NUM_W-1:0] nm;
   } num_set_type;

   // Rounded levels
   typedef struct packed {
      logic [CH_W-1:0] vc;
      logic [CH_W-1:0] vx;
      logic [CH_W-1:0] vm;
   } level_set_type;

endpackage

@@ rtl/core/hsl_to_rgb_converter.sv @@
// HSL to RGB converter, one pixel per clock.
// Input: pulse start with req_hue, req_saturation and req_lightness
// (8 bits each). busy is tied low, so a transfer happens at every edge
// where start is high; a new pixel may follow in the very next cycle.
// Output: rsp_valid is high for exactly one cycle with rsp_red,
// rsp_green and rsp_blue; the receiver takes the transfer in that cycle.
// Throughput: one pixel per cycle, set by the six-stage pipeline with no
// shared unit; an input transfer passes through the stages in order:
//   1 lightness distance, hue sector and triangle
//   2 A*S and L*DEN
//   3 42*A*S and 2*A*S*T, C and m numerators
//   4 X numerator plus rounding offset
//   5 reciprocal multiply by 1/DEN (quotient unit)
//   6 sector permutation into the output register
// Reset (synchronous, active high) clears all stage valid bits; items
// in flight are dropped and no strobe is produced for them.
module hsl_to_rgb_converter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [hsl_pkg::CH_W-1:0]    req_hue,
   input  logic [hsl_pkg::CH_W-1:0]    req_saturation,
   input  logic [hsl_pkg::CH_W-1:0]    req_lightness,
   output logic                        rsp_valid,
   output logic [hsl_pkg::CH_W-1:0]    rsp_red,
   output logic [hsl_pkg::CH_W-1:0]    rsp_green,
   output logic [hsl_pkg::CH_W-1:0]    rsp_blue
);

   localparam int unsigned CW   = hsl_pkg::CH_W;
   localparam int unsigned NW   = hsl_pkg::NUM_W;
   localparam int unsigned TW   = 6;          // triangle 0..42
   localparam int unsigned HMW  = 7;          // hue mod 84
   localparam int unsigned ASW  = 2 * CW;     // A*S
   localparam int unsigned HCW  = 22;         // 42*A*S
   localparam int unsigned XPW  = 23;         // 2*A*S*T

   logic accept;

   // ---------------- stage 1 ----------------
   logic [CW:0]          twol;
   logic [CW-1:0]        light_dev;
   logic [CW-1:0]        a1_in;
   logic [HMW-1:0]       hm;
   logic [TW-1:0]        t1_in;
   hsl_pkg::sector_type  sec1_in;

   logic                 v1_ff;
   logic [CW-1:0]        a1_ff;
   logic [CW-1:0]        s1_ff;
   logic [CW-1:0]        l1_ff;
   logic [TW-1:0]        t1_ff;
   hsl_pkg::sector_type  sec1_ff;

   // ---------------- stage 2 ----------------
   logic                 v2_ff;
   logic [ASW-1:0]       as2_ff;
   logic [NW-1:0]        base2_ff;
   logic [TW-1:0]        t2_ff;
   hsl_pkg::sector_type  sec2_ff;

   // ---------------- stage 3 ----------------
   logic [HCW-1:0]       halfc;
   logic [XPW-1:0]       xpart3_in;
   logic                 v3_ff;
   logic [NW-1:0]        nc3_ff;
   logic [NW-1:0]        nm3_ff;
   logic [XPW-1:0]       xp3_ff;
   hsl_pkg::sector_type  sec3_ff;

   // ---------------- stage 4 ----------------
   hsl_pkg::num_set_type num4_in;
   hsl_pkg::num_set_type num4_ff;
   logic                 v4_ff;
   hsl_pkg::sector_type  sec4_ff;

   // ---------------- stage 5 / 6 ----------------
   logic                   v5;
   hsl_pkg::level_set_type lvl5;
   hsl_pkg::sector_type    sec5;
   logic                   v6_ff;
   logic [CW-1:0]          red_in, green_in, blue_in;
   logic [CW-1:0]          red_ff, green_ff, blue_ff;

   // Pipeline never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Stage 1: A = 255 - |2L - 255|, hue sector and triangle
   always_comb begin
      twol      = {req_lightness, 1'b0};
      light_dev = (twol >= (CW+1)'(255)) ? CW'(twol - (CW+1)'(255))
                                         : CW'((CW+1)'(255) - twol);
      a1_in     = CW'(255) - light_dev;

      // hue mod 84; hue 252..255 starts a fresh period
      if (req_hue < CW'(hsl_pkg::HUE_PERIOD)) begin
         hm = HMW'(req_hue);
      end else if (req_hue < CW'(2 * hsl_pkg::HUE_PERIOD)) begin
         hm = HMW'(req_hue - CW'(hsl_pkg::HUE_PERIOD));
      end else if (req_hue < CW'(3 * hsl_pkg::HUE_PERIOD)) begin
         hm = HMW'(req_hue - CW'(2 * hsl_pkg::HUE_PERIOD));
      end else begin
         hm = HMW'(req_hue - CW'(3 * hsl_pkg::HUE_PERIOD));
      end
      t1_in = (hm >= HMW'(hsl_pkg::SECTOR_LEN))
              ? TW'(HMW'(hsl_pkg::HUE_PERIOD) - hm) : TW'(hm);

      priority if (req_hue < CW'(hsl_pkg::SECTOR_LEN)) begin
         sec1_in = hsl_pkg::SEC_RED_YEL;
      end else if (req_hue < CW'(2 * hsl_pkg::SECTOR_LEN)) begin
         sec1_in = hsl_pkg::SEC_YEL_GRN;
      end else if (req_hue < CW'(3 * hsl_pkg::SECTOR_LEN)) begin
         sec1_in = hsl_pkg::SEC_GRN_CYN;
      end else if (req_hue < CW'(4 * hsl_pkg::SECTOR_LEN)) begin
         sec1_in = hsl_pkg::SEC_CYN_BLU;
      end else if (req_hue < CW'(5 * hsl_pkg::SECTOR_LEN)) begin
         sec1_in = hsl_pkg::SEC_BLU_MAG;
      end else begin
         sec1_in = hsl_pkg::SEC_MAG_RED;
      end
   end

   // Stage 3 combinational: 42*A*S and 2*A*S*T
   assign halfc     = HCW'(as2_ff) * HCW'(hsl_pkg::SECTOR_LEN);
   assign xpart3_in = (XPW'(as2_ff) * XPW'(t2_ff)) << 1;

   // Stage 4 combinational: X numerator and rounding offset
   always_comb begin
      num4_in.nc = nc3_ff + NW'(hsl_pkg::HALF_DEN);
      num4_in.nm = nm3_ff + NW'(hsl_pkg::HALF_DEN);
      num4_in.nx = nm3_ff + NW'(xp3_ff) + NW'(hsl_pkg::HALF_DEN);
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v6_ff <= v5;
      end
   end

   // Payload stages 1-4
   always_ff @(posedge clock) begin
      a1_ff    <= a1_in;
      s1_ff    <= req_saturation;
      l1_ff    <= req_lightness;
      t1_ff    <= t1_in;
      sec1_ff  <= sec1_in;

      as2_ff   <= ASW'(a1_ff) * ASW'(s1_ff);
      base2_ff <= NW'(l1_ff) * NW'(hsl_pkg::DEN);
      t2_ff    <= t1_ff;
      sec2_ff  <= sec1_ff;

      nc3_ff   <= base2_ff + NW'(halfc);
      nm3_ff   <= base2_ff - NW'(halfc);
      xp3_ff   <= xpart3_in;
      sec3_ff  <= sec2_ff;

      num4_ff  <= num4_in;
      sec4_ff  <= sec3_ff;
   end

   // Stage 5: divide by DEN
   hsl_quot u_quot (
      .clock      (clock),
      .reset      (reset),
      .num_valid  (v4_ff),
      .num        (num4_ff),
      .num_sector (sec4_ff),
      .lvl_valid  (v5),
      .lvl        (lvl5),
      .lvl_sector (sec5)
   );

   // Stage 6: sector permutation
   always_comb begin
      unique case (sec5)
         hsl_pkg::SEC_RED_YEL: begin
            red_in = lvl5.vc; green_in = lvl5.vx; blue_in = lvl5.vm;
         end
         hsl_pkg::SEC_YEL_GRN: begin
            red_in = lvl5.vx; green_in = lvl5.vc; blue_in = lvl5.vm;
         end
         hsl_pkg::SEC_GRN_CYN: begin
            red_in = lvl5.vm; green_in = lvl5.vc; blue_in = lvl5.vx;
         end
         hsl_pkg::SEC_CYN_BLU: begin
            red_in = lvl5.vm; green_in = lvl5.vx; blue_in = lvl5.vc;
         end
         hsl_pkg::SEC_BLU_MAG: begin
            red_in = lvl5.vx; green_in = lvl5.vm; blue_in = lvl5.vc;
         end
         default: begin
            red_in = lvl5.vc; green_in = lvl5.vm; blue_in = lvl5.vx;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_valid = v6_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // Assertions

   // An input transfer enters stage 1 on the next cycle
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("input transfer did not enter the pipeline");

   // A quotient-stage item always reaches the output register
   a_quot_to_out: assert property (@(posedge clock) disable iff (reset)
      v5 |=> rsp_valid)
      else $error("item lost between quotient and output stage");

   // Zero saturation gives a gray pixel
   a_gray: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_saturation, 6) == '0)) |->
         ((rsp_red == rsp_green) && (rsp_green == rsp_blue)))
      else $error("zero saturation did not give equal components");

   // Full lightness gives white
   a_white: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_lightness, 6) == '1)) |->
         ((rsp_red == '1) && (rsp_green == '1) && (rsp_blue == '1)))
      else $error("full lightness did not give white");

endmodule

@@ rtl/core/hsl_quot.sv @@
// Divide three rounded numerators by DEN with a reciprocal multiply,
// one register stage. Sector code rides along with the valid bit.
module hsl_quot (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  num_valid,
   input  hsl_pkg::num_set_type  num,
   input  hsl_pkg::sector_type   num_sector,
   output logic                  lvl_valid,
   output hsl_pkg::level_set_type lvl,
   output hsl_pkg::sector_type   lvl_sector
);

   localparam int unsigned PROD_W = hsl_pkg::NUM_W + hsl_pkg::RECIP_W;

   logic [PROD_W-1:0]       prod_c;
   logic [PROD_W-1:0]       prod_x;
   logic [PROD_W-1:0]       prod_m;
   logic                    valid_ff;
   hsl_pkg::level_set_type  lvl_ff;
   hsl_pkg::level_set_type  lvl_in;
   hsl_pkg::sector_type     sector_ff;

   // Reciprocal products; quotient is at most 255
   assign prod_c = PROD_W'(num.nc) * PROD_W'(hsl_pkg::RECIP);
   assign prod_x = PROD_W'(num.nx) * PROD_W'(hsl_pkg::RECIP);
   assign prod_m = PROD_W'(num.nm) * PROD_W'(hsl_pkg::RECIP);

   always_comb begin
      lvl_in.vc = prod_c[hsl_pkg::RECIP_SHIFT +: hsl_pkg::CH_W];
      lvl_in.vx = prod_x[hsl_pkg::RECIP_SHIFT +: hsl_pkg::CH_W];
      lvl_in.vm = prod_m[hsl_pkg::RECIP_SHIFT +: hsl_pkg::CH_W];
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= num_valid;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      lvl_ff    <= lvl_in;
      sector_ff <= num_sector;
   end

   assign lvl_valid  = valid_ff;
   assign lvl        = lvl_ff;
   assign lvl_sector = sector_ff;

endmodule

@@ tb/tb_hsl_to_rgb_converter.sv @@
module tb_hsl_to_rgb_converter;

   // Fixed-point scale of the predictor: levels times 255 over LEVEL_DEN
   localparam int unsigned LEVEL_DEN  = 21420;
   localparam int unsigned LEVEL_HALF = LEVEL_DEN / 2;
   localparam int unsigned HUE_SPAN   = 42;
   localparam int unsigned HUE_CYCLE  = 2 * HUE_SPAN;
   localparam int unsigned FULL       = 255;

   localparam int RANDOM_PIXELS = 630;
   localparam int QUIET_TAIL    = 80;    // last pixels go out back to back
   localparam int DRAIN_LIMIT   = 200;   // cycles allowed to empty the pipe
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      logic [hsl_pkg::CH_W-1:0] hue;
      logic [hsl_pkg::CH_W-1:0] sat;
      logic [hsl_pkg::CH_W-1:0] light;
   } hsl_pixel_type;

   typedef struct packed {
      logic [hsl_pkg::CH_W-1:0] red;
      logic [hsl_pkg::CH_W-1:0] green;
      logic [hsl_pkg::CH_W-1:0] blue;
   } rgb_pixel_type;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     start          = 1'b0;
   logic                     busy;
   logic [hsl_pkg::CH_W-1:0] req_hue        = '0;
   logic [hsl_pkg::CH_W-1:0] req_saturation = '0;
   logic [hsl_pkg::CH_W-1:0] req_lightness  = '0;
   logic                     rsp_valid;
   logic [hsl_pkg::CH_W-1:0] rsp_red;
   logic [hsl_pkg::CH_W-1:0] rsp_green;
   logic [hsl_pkg::CH_W-1:0] rsp_blue;

   hsl_pixel_type hsl_pixels_q[$];
   rgb_pixel_type pending_rgb_q[$];
   rgb_pixel_type want_rgb;
   int            idle_left   = 0;
   int            transfers   = 0;
   int            error_count = 0;

   hsl_to_rgb_converter dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   always #5 clock = ~clock;

   // Round a scaled numerator to nearest, ties upward
   function automatic logic [hsl_pkg::CH_W-1:0] round_level(int unsigned num);
      return hsl_pkg::CH_W'((num + LEVEL_HALF) / LEVEL_DEN);
   endfunction

   // Expected color of one pixel
   function automatic rgb_pixel_type convert_pixel(hsl_pixel_type px);
      int unsigned l, light_dev, a, hm, ramp, as_prod, base, half_c;
      logic [hsl_pkg::CH_W-1:0] lvl_c, lvl_m, lvl_x;
      int unsigned          sec_idx;
      hsl_pkg::sector_type  sec;
      rgb_pixel_type        rgb;
      l         = px.light;
      light_dev = (2 * l >= FULL) ? 2 * l - FULL : FULL - 2 * l;
      a         = FULL - light_dev;
      hm        = px.hue % HUE_CYCLE;
      ramp      = (hm >= HUE_SPAN) ? HUE_CYCLE - hm : hm;
      as_prod   = a * px.sat;
      base      = LEVEL_DEN * l;
      half_c    = HUE_SPAN * as_prod;
      lvl_c     = round_level(base + half_c);
      lvl_m     = round_level(base - half_c);
      lvl_x     = round_level(base - half_c + 2 * as_prod * ramp);
      // hue 252..255 stays in the last sector
      sec_idx = px.hue / HUE_SPAN;
      if (sec_idx > 5) sec_idx = 5;
      sec = hsl_pkg::sector_type'(sec_idx);
      case (sec)
         hsl_pkg::SEC_RED_YEL: rgb = '{lvl_c, lvl_x, lvl_m};
         hsl_pkg::SEC_YEL_GRN: rgb = '{lvl_x, lvl_c, lvl_m};
         hsl_pkg::SEC_GRN_CYN: rgb = '{lvl_m, lvl_c, lvl_x};
         hsl_pkg::SEC_CYN_BLU: rgb = '{lvl_m, lvl_x, lvl_c};
         hsl_pkg::SEC_BLU_MAG: rgb = '{lvl_x, lvl_m, lvl_c};
         default:              rgb = '{lvl_c, lvl_m, lvl_x};
      endcase
      return rgb;
   endfunction

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      $display("ERROR at %0t: %s: expected %0d, got %0d", $time, what, want, got);
      error_count++;
   endtask

   // Driver: one pixel per transfer, random idle bursts except near the end
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         idle_left <= 0;
      end else if (start && busy) begin
         // block not ready, hold the pixel
      end else if (idle_left > 0) begin
         start     <= 1'b0;
         idle_left <= idle_left - 1;
      end else if (hsl_pixels_q.size() > 0) begin
         req_hue        <= hsl_pixels_q[0].hue;
         req_saturation <= hsl_pixels_q[0].sat;
         req_lightness  <= hsl_pixels_q[0].light;
         start          <= 1'b1;
         if (hsl_pixels_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
            idle_left <= $urandom_range(1, 10);
         void'(hsl_pixels_q.pop_front());
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: check results first, then record the pixel taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_rgb_q.size() == 0) begin
               report_mismatch("result with nothing pending", 0, 1);
            end else begin
               want_rgb = pending_rgb_q.pop_front();
               if (rsp_red !== want_rgb.red)
                  report_mismatch("red", want_rgb.red, rsp_red);
               if (rsp_green !== want_rgb.green)
                  report_mismatch("green", want_rgb.green, rsp_green);
               if (rsp_blue !== want_rgb.blue)
                  report_mismatch("blue", want_rgb.blue, rsp_blue);
            end
         end
         if (start && !busy) begin
            pending_rgb_q.push_back(
               convert_pixel('{req_hue, req_saturation, req_lightness}));
            transfers++;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      hsl_pixel_type px;
      int            total;
      int            drain;
      int            hue_i;

      // directed: extremes of each field, every sector edge, mid lightness
      hsl_pixels_q.push_back('{8'd0,   8'd0,   8'd0});
      hsl_pixels_q.push_back('{8'd255, 8'd255, 8'd255});
      hsl_pixels_q.push_back('{8'd0,   8'd255, 8'd255});
      hsl_pixels_q.push_back('{8'd0,   8'd255, 8'd0});
      hsl_pixels_q.push_back('{8'd0,   8'd255, 8'd127});
      hsl_pixels_q.push_back('{8'd0,   8'd255, 8'd128});
      hsl_pixels_q.push_back('{8'd0,   8'd0,   8'd128});
      hsl_pixels_q.push_back('{8'd41,  8'd255, 8'd128});
      hsl_pixels_q.push_back('{8'd42,  8'd255, 8'd128});
      hsl_pixels_q.push_back('{8'd83,  8'd255, 8'd128});
      hsl_pixels_q.push_back('{8'd84,  8'd255, 8'd128});
      hsl_pixels_q.push_back('{8'd125, 8'd255, 8'd128});
      hsl_pixels_q.push_back('{8'd126, 8'd255, 8'd128});
      hsl_pixels_q.push_back('{8'd167, 8'd255, 8'd128});
      hsl_pixels_q.push_back('{8'd168, 8'd255, 8'd128});
      hsl_pixels_q.push_back('{8'd209, 8'd255, 8'd128});
      hsl_pixels_q.push_back('{8'd210, 8'd255, 8'd127});
      // last sector, triangle restarting past 251
      hsl_pixels_q.push_back('{8'd251, 8'd255, 8'd128});
      hsl_pixels_q.push_back('{8'd252, 8'd255, 8'd128});
      hsl_pixels_q.push_back('{8'd255, 8'd255, 8'd127});
      hsl_pixels_q.push_back('{8'd200, 8'd1,   8'd1});
      hsl_pixels_q.push_back('{8'd100, 8'd254, 8'd254});
      hsl_pixels_q.push_back('{8'd30,  8'd128, 8'd64});
      hsl_pixels_q.push_back('{8'd170, 8'd85,  8'd170});

      // random: mostly uniform, some near sector edges and level extremes
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         px.hue   = hsl_pkg::CH_W'($urandom_range(0, 255));
         px.sat   = hsl_pkg::CH_W'($urandom_range(0, 255));
         px.light = hsl_pkg::CH_W'($urandom_range(0, 255));
         if ($urandom_range(0, 4) == 0) begin
            hue_i  = HUE_SPAN * $urandom_range(0, 6) + $urandom_range(0, 2) - 1;
            px.hue = (hue_i < 0) ? 8'd0 : hsl_pkg::CH_W'(hue_i);
         end
         if ($urandom_range(0, 4) == 0)
            px.sat = $urandom_range(0, 1) ? 8'd255
                                          : hsl_pkg::CH_W'($urandom_range(0, 2));
         if ($urandom_range(0, 4) == 0)
            px.light = hsl_pkg::CH_W'($urandom_range(0, 1)
                                      ? $urandom_range(126, 129)
                                      : $urandom_range(0, 1) * 255);
         hsl_pixels_q.push_back(px);
      end
      total = hsl_pixels_q.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (transfers == total);
      drain = 0;
      while (pending_rgb_q.size() > 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_rgb_q.size() > 0)
         report_mismatch("results never delivered", 0, pending_rgb_q.size());

      if (error_count == 0) begin
         $display("tb_hsl_to_rgb_converter: done, clean");
      end else begin
         $display("tb_hsl_to_rgb_converter: done, errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("tb_hsl_to_rgb_converter: done, errors");
      $finish;
   end

endmodule
